// ===== sv/bfs_pkg.sv =====
// Shared types and constants for the blink/fade sequencer.
// Used by the divider and the top level.
package bfs_pkg;

  // Default widths
  localparam int TIME_BITS_DEF  = 24;
  localparam int COUNT_BITS_DEF = 8;

  // Fixed field widths
  localparam int STEP_BITS   = 16;
  localparam int ALPHA_BITS  = 9;
  localparam int PCOUNT_BITS = 8;
  localparam int QUOT_BITS   = 8;
  localparam int IDX_BITS    = 3;

  // Fade levels in Q1.8
  localparam logic [ALPHA_BITS-1:0] ALPHA_CLAMP = 9'd179;
  localparam logic [ALPHA_BITS-1:0] ALPHA_FULL  = 9'd256;
  localparam logic [ALPHA_BITS-1:0] ALPHA_ZERO  = 9'd0;

  // Register reset values
  localparam int RST_INITIAL_DELAY = 1000;
  localparam int RST_ON_TIME       = 1000;
  localparam int RST_OFF_TIME      = 1000;
  localparam int RST_FADE_START    = 500;
  localparam int RST_END_DELAY     = 0;
  localparam logic [PCOUNT_BITS-1:0] RST_PHASE_COUNT = 8'd0;
  localparam logic RST_START_VISIBLE  = 1'b1;
  localparam logic RST_REPEAT_FOREVER = 1'b1;

  typedef enum logic [IDX_BITS-1:0] {
    REG_INITIAL_DELAY  = 3'd0,
    REG_ON_TIME        = 3'd1,
    REG_OFF_TIME       = 3'd2,
    REG_FADE_START     = 3'd3,
    REG_END_DELAY      = 3'd4,
    REG_PHASE_COUNT    = 3'd5,
    REG_START_VISIBLE  = 3'd6,
    REG_REPEAT_FOREVER = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ENTER  = 2'd1,
    CMD_LEAVE  = 2'd2,
    CMD_ENABLE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2,
    PH_END  = 2'd3
  } phase_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic                 done;
    logic [QUOT_BITS-1:0] quot;
  } div_resp_t;

endpackage

// ===== sv/bfs_if.sv =====
// Valid/ready channel interfaces for the blink/fade sequencer.
// Input beat carries one command; output beat carries one status result.
interface bfs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] step_time;
  logic        enable_value;

  modport source (output valid, command, step_time, enable_value, input ready);
  modport sink   (input valid, command, step_time, enable_value, output ready);
endinterface

interface bfs_out_if;
  logic       valid;
  logic       ready;
  logic       visible_now;
  logic [8:0] fade_alpha;
  logic [1:0] current_phase;
  logic       block_alert_valid;
  logic       block_alert_level;
  logic       finish_alert;

  modport source (output valid, visible_now, fade_alpha, current_phase,
                  block_alert_valid, block_alert_level, finish_alert, input ready);
  modport sink   (input valid, visible_now, fade_alpha, current_phase,
                  block_alert_valid, block_alert_level, finish_alert, output ready);
endinterface

// ===== sv/bfs_div.sv =====
// Restoring divider, one quotient bit per cycle, for the fade ratio.
// Depends on bfs_pkg; expects dividend < divisor so the quotient fits 8 bits.
module bfs_div #(
  parameter int TIME_BITS = bfs_pkg::TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [TIME_BITS-1:0]  dividend,
  input  logic [TIME_BITS-1:0]  divisor,
  output bfs_pkg::div_resp_t    resp
);
  import bfs_pkg::*;

  localparam int CNT_BITS = $clog2(QUOT_BITS);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic [TIME_BITS-1:0] rem_r;
  logic [TIME_BITS-1:0] dvs_r;
  logic [QUOT_BITS-1:0] quot_r;

  logic [TIME_BITS:0]   rem_dbl;
  logic                 fits;
  logic [TIME_BITS:0]   rem_sub;

  // Shift remainder and trial-subtract the divisor
  assign rem_dbl = {rem_r, 1'b0};
  assign fits    = rem_dbl >= {1'b0, dvs_r};
  assign rem_sub = rem_dbl - {1'b0, dvs_r};

  // Control: count eight steps, pulse done after the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_BITS'(QUOT_BITS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(QUOT_BITS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend;
      dvs_r  <= divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? rem_sub[TIME_BITS-1:0] : rem_dbl[TIME_BITS-1:0];
      quot_r <= {quot_r[QUOT_BITS-2:0], fits};
    end
  end

  assign resp.done = done_r;
  assign resp.quot = quot_r;

endmodule

// ===== sv/blink_fade_sequencer.sv =====
// Top level of the blink/fade sequencer: config registers, sequencer FSM.
// Depends on bfs_pkg, bfs_if (channel interfaces) and bfs_div.
//
// Usage:
//   in_bus carries command beats (tick, presence enter, presence leave,
//   set enable); out_bus returns exactly one status beat per command.
//   Configuration goes through cfg_we/cfg_index/cfg_data while idle.
// Timing:
//   One command at a time; in_bus.ready is high only when idle.
//   out_bus.valid rises after the S_ADD state for presence and enable commands;
//   a tick with run enabled also passes S_EVAL, and a tick that updates the
//   fade level waits in S_DIV for the eight-step serial divider.
//   The block is ready again in the cycle after the result beat is taken,
//   so a new command is taken only after the previous result beat.
// Reset:
//   rst_n (synchronous, active low) loads the default register values
//   and restarts the sequence in the initial delay phase with run enabled.
// Stall:
//   A result beat is held stable until out_bus.ready; no new command is
//   taken meanwhile.
module blink_fade_sequencer #(
  parameter int TIME_BITS  = bfs_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = bfs_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bfs_in_if.sink                        in_bus,
  bfs_out_if.source                     out_bus,
  input  logic                          cfg_we,
  input  logic [bfs_pkg::IDX_BITS-1:0]  cfg_index,
  input  logic [TIME_BITS-1:0]          cfg_data
);
  import bfs_pkg::*;

  localparam int EL_BITS  = TIME_BITS + 1;
  localparam int SUM_BITS = ((EL_BITS > STEP_BITS) ? EL_BITS : STEP_BITS) + 1;
  localparam logic [EL_BITS-1:0] EL_MAX = '1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_EVAL = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  // Configuration registers
  logic [TIME_BITS-1:0]   initial_delay_r, on_time_r, off_time_r;
  logic [TIME_BITS-1:0]   fade_start_r, end_delay_r;
  logic [PCOUNT_BITS-1:0] phase_count_r;
  logic                   start_visible_r, repeat_forever_r;

  // Sequence state
  state_t                 state_r, state_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [EL_BITS-1:0]     elapsed_r, elapsed_nxt;
  logic [COUNT_BITS-1:0]  changes_r, changes_nxt;
  logic                   limit_r, limit_nxt;
  logic                   shown_r, shown_nxt;
  logic                   presence_r, presence_nxt;
  logic                   done_flag_r, done_flag_nxt;
  logic [ALPHA_BITS-1:0]  alpha_r, alpha_nxt;
  logic                   run_en_r, run_en_nxt;

  // Latched beat and result flags
  cmd_t                   cmd_r;
  logic [STEP_BITS-1:0]   dt_r;
  logic                   en_r;
  logic                   alert_v_r, alert_v_nxt;
  logic                   alert_l_r, alert_l_nxt;
  logic                   finish_r, finish_nxt;

  logic                   div_start;
  div_resp_t              div_resp;
  logic [SUM_BITS-1:0]    el_sum;
  logic [COUNT_BITS-1:0]  count_load;
  logic                   in_fire;

  assign in_fire    = in_bus.valid && in_bus.ready;
  assign count_load = COUNT_BITS'(phase_count_r);
  assign el_sum     = SUM_BITS'(elapsed_r) + SUM_BITS'(dt_r);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_delay_r  <= TIME_BITS'(RST_INITIAL_DELAY);
      on_time_r        <= TIME_BITS'(RST_ON_TIME);
      off_time_r       <= TIME_BITS'(RST_OFF_TIME);
      fade_start_r     <= TIME_BITS'(RST_FADE_START);
      end_delay_r      <= TIME_BITS'(RST_END_DELAY);
      phase_count_r    <= RST_PHASE_COUNT;
      start_visible_r  <= RST_START_VISIBLE;
      repeat_forever_r <= RST_REPEAT_FOREVER;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_INITIAL_DELAY:  initial_delay_r  <= cfg_data;
        REG_ON_TIME:        on_time_r        <= cfg_data;
        REG_OFF_TIME:       off_time_r       <= cfg_data;
        REG_FADE_START:     fade_start_r     <= cfg_data;
        REG_END_DELAY:      end_delay_r      <= cfg_data;
        REG_PHASE_COUNT:    phase_count_r    <= cfg_data[PCOUNT_BITS-1:0];
        REG_START_VISIBLE:  start_visible_r  <= cfg_data[0];
        REG_REPEAT_FOREVER: repeat_forever_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    elapsed_nxt   = elapsed_r;
    changes_nxt   = changes_r;
    limit_nxt     = limit_r;
    shown_nxt     = shown_r;
    presence_nxt  = presence_r;
    done_flag_nxt = done_flag_r;
    alpha_nxt     = alpha_r;
    run_en_nxt    = run_en_r;
    alert_v_nxt   = alert_v_r;
    alert_l_nxt   = alert_l_r;
    finish_nxt    = finish_r;
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          alert_v_nxt = 1'b0;
          alert_l_nxt = 1'b0;
          finish_nxt  = 1'b0;
          state_nxt   = S_ADD;
        end
      end

      // Apply presence/enable, or force limit and accumulate time
      S_ADD: begin
        state_nxt = S_OUT;
        case (cmd_r)
          CMD_TICK: begin
            if (limit_r && (changes_r == '0)) phase_nxt = PH_END;
            if (run_en_r) begin
              elapsed_nxt = (el_sum[SUM_BITS-1:EL_BITS] != '0) ? EL_MAX
                                                              : el_sum[EL_BITS-1:0];
              state_nxt   = S_EVAL;
            end
          end
          CMD_ENTER: begin
            presence_nxt = 1'b1;
            if (!shown_r) begin
              alert_v_nxt = 1'b1;
              alert_l_nxt = 1'b1;
            end
          end
          CMD_LEAVE: begin
            presence_nxt = 1'b0;
            alert_v_nxt  = 1'b1;
            alert_l_nxt  = 1'b0;
          end
          default: begin
            run_en_nxt = en_r;
            if (en_r) begin
              phase_nxt     = PH_INIT;
              shown_nxt     = start_visible_r;
              alpha_nxt     = start_visible_r ? ALPHA_ZERO : ALPHA_FULL;
              presence_nxt  = 1'b0;
              changes_nxt   = count_load;
              limit_nxt     = count_load != '0;
              elapsed_nxt   = '0;
              done_flag_nxt = 1'b0;
            end
          end
        endcase
      end

      // Phase decisions on the updated elapsed time
      S_EVAL: begin
        state_nxt = S_OUT;
        case (phase_r)
          PH_INIT: begin
            if (elapsed_r >= EL_BITS'(initial_delay_r)) begin
              phase_nxt   = start_visible_r ? PH_ON : PH_OFF;
              elapsed_nxt = '0;
            end
          end
          PH_ON: begin
            if (elapsed_r >= EL_BITS'(on_time_r)) begin
              if (limit_r && (changes_r != '0)) changes_nxt = changes_r - 1'b1;
              shown_nxt = 1'b0;
              if (presence_r) begin
                alert_v_nxt = 1'b1;
                alert_l_nxt = 1'b1;
              end
              phase_nxt   = PH_OFF;
              alpha_nxt   = ALPHA_FULL;
              elapsed_nxt = '0;
            end else if (elapsed_r >= EL_BITS'(fade_start_r)) begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
          PH_OFF: begin
            if (elapsed_r >= EL_BITS'(off_time_r)) begin
              if (limit_r && (changes_r != '0)) changes_nxt = changes_r - 1'b1;
              shown_nxt   = 1'b1;
              phase_nxt   = PH_ON;
              alpha_nxt   = ALPHA_ZERO;
              elapsed_nxt = '0;
            end
          end
          default: begin
            if (elapsed_r >= EL_BITS'(end_delay_r)) begin
              elapsed_nxt = '0;
              phase_nxt   = repeat_forever_r ? PH_INIT : PH_END;
              if (!repeat_forever_r && !done_flag_r) begin
                finish_nxt    = 1'b1;
                done_flag_nxt = 1'b1;
              end
              shown_nxt   = start_visible_r;
              changes_nxt = repeat_forever_r ? count_load : '0;
            end
          end
        endcase
      end

      // Wait for the fade ratio, clamp it
      S_DIV: begin
        if (div_resp.done) begin
          alpha_nxt = (ALPHA_BITS'(div_resp.quot) > ALPHA_CLAMP) ? ALPHA_CLAMP
                                                                : ALPHA_BITS'(div_resp.quot);
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (out_bus.ready) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_INIT;
      elapsed_r   <= '0;
      changes_r   <= COUNT_BITS'(RST_PHASE_COUNT);
      limit_r     <= RST_PHASE_COUNT != '0;
      shown_r     <= RST_START_VISIBLE;
      presence_r  <= 1'b0;
      done_flag_r <= 1'b0;
      alpha_r     <= RST_START_VISIBLE ? ALPHA_ZERO : ALPHA_FULL;
      run_en_r    <= 1'b1;
      alert_v_r   <= 1'b0;
      alert_l_r   <= 1'b0;
      finish_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      changes_r   <= changes_nxt;
      limit_r     <= limit_nxt;
      shown_r     <= shown_nxt;
      presence_r  <= presence_nxt;
      done_flag_r <= done_flag_nxt;
      alpha_r     <= alpha_nxt;
      run_en_r    <= run_en_nxt;
      alert_v_r   <= alert_v_nxt;
      alert_l_r   <= alert_l_nxt;
      finish_r    <= finish_nxt;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= cmd_t'(in_bus.command);
      dt_r  <= in_bus.step_time;
      en_r  <= in_bus.enable_value;
    end
  end

  // Fade ratio: elapsed * 256 / on_time, elapsed below on_time here
  bfs_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (elapsed_r[TIME_BITS-1:0]),
    .divisor  (on_time_r),
    .resp     (div_resp)
  );

  // Channel outputs
  assign in_bus.ready              = (state_r == S_IDLE);
  assign out_bus.valid             = (state_r == S_OUT);
  assign out_bus.visible_now       = shown_r;
  assign out_bus.fade_alpha        = alpha_r;
  assign out_bus.current_phase     = phase_r;
  assign out_bus.block_alert_valid = alert_v_r;
  assign out_bus.block_alert_level = alert_l_r;
  assign out_bus.finish_alert      = finish_r;

endmodule
